// ----- hw/rtl/fms_pkg.sv -----
// types, constants and helper functions for the flight mode supervisor
package fms_pkg;

   localparam int unsigned LimitWidth = 15;
   localparam int unsigned FieldWidth = 16;
   localparam int unsigned ReqDataWidth = 176;
   localparam int unsigned RspDataWidth = 80;
   localparam int unsigned CsrAddrWidth = 3;

   localparam logic [LimitWidth-1:0] XyLimitReset = 15'd2500;
   localparam logic [LimitWidth-1:0] TiltLimitReset = 15'd524;
   localparam logic [LimitWidth-1:0] RateLimitReset = 15'd13963;
   localparam logic [LimitWidth-1:0] TakeoffHeightReset = 15'd800;
   localparam logic [LimitWidth-1:0] LandedHeightReset = 15'd200;

   localparam logic signed [FieldWidth-1:0] MotorOne = 16'sd16384;
   localparam logic [10:0] RatioScale = 11'd1875;

   typedef enum logic [2:0] {
      MODE_GROUND  = 3'd0,
      MODE_TAKEOFF = 3'd1,
      MODE_HOVER   = 3'd2,
      MODE_EXEC    = 3'd3,
      MODE_LAND    = 3'd4,
      MODE_INIT    = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      CMD_HOVER = 3'd0,
      CMD_LAND  = 3'd1,
      CMD_PWM   = 3'd2,
      CMD_START = 3'd3,
      CMD_NONE  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      SP_NONE  = 2'd0,
      SP_HOVER = 2'd1,
      SP_LAND  = 2'd2,
      SP_RESET = 2'd3
   } setpoint_type;

   typedef enum logic [CsrAddrWidth-1:0] {
      REG_XY_LIMIT       = 3'd0,
      REG_TILT_LIMIT     = 3'd1,
      REG_RATE_LIMIT     = 3'd2,
      REG_TAKEOFF_HEIGHT = 3'd3,
      REG_LANDED_HEIGHT  = 3'd4
   } reg_index_type;

   // true when |v| > lim
   function automatic logic beyond(input logic signed [FieldWidth-1:0] v,
                                   input logic [LimitWidth-1:0] lim);
      logic signed [FieldWidth:0] vx;
      logic signed [FieldWidth:0] lx;
      vx = {v[FieldWidth-1], v};
      lx = {2'b00, lim};
      return (vx > lx) || (vx < -lx);
   endfunction

   function automatic logic above(input logic signed [FieldWidth-1:0] v,
                                  input logic [LimitWidth-1:0] lim);
      logic signed [FieldWidth:0] vx;
      logic signed [FieldWidth:0] lx;
      vx = {v[FieldWidth-1], v};
      lx = {2'b00, lim};
      return vx > lx;
   endfunction

   function automatic logic below(input logic signed [FieldWidth-1:0] v,
                                  input logic [LimitWidth-1:0] lim);
      logic signed [FieldWidth:0] vx;
      logic signed [FieldWidth:0] lx;
      vx = {v[FieldWidth-1], v};
      lx = {2'b00, lim};
      return vx < lx;
   endfunction

   // clamp to +-1.0 in q2.14, shift to 0..2.0, scale by 30000
   function automatic logic [FieldWidth-1:0] motor_ratio(
      input logic signed [FieldWidth-1:0] q);
      logic signed [FieldWidth-1:0] qc;
      logic [FieldWidth-1:0] offset;
      logic [26:0] product;
      if (q > MotorOne) begin
         qc = MotorOne;
      end else if (q < -MotorOne) begin
         qc = -MotorOne;
      end else begin
         qc = q;
      end
      offset = FieldWidth'(qc + MotorOne);
      product = 27'(offset) * 27'(RatioScale);
      return product[25:10];
   endfunction

endpackage

// ----- hw/rtl/flight_mode_supervisor.sv -----
// flight mode supervisor top level: mode state machine, envelope check, motor scaling
//
// One control tick per transaction. A tick is captured in an input register, evaluated
// against the current flight mode and bypass flag by single-cycle logic, and written to
// the result register while mode and bypass update in the same edge, so a new tick can be
// accepted every clock cycle while the response side is not stalled. The result register
// holds a finished result while the next tick waits in the input register, and the input
// side stalls only when both are full. The user must write limit registers through the
// csr port only while the block is idle (not enforced); they take effect on the next tick.
module flight_mode_supervisor
   import fms_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_tvalid,
   output logic                           req_tready,
   // motor_a, motor_b, motor_c, motor_d, pos_x, pos_y, height,
   // roll_angle, pitch_angle, roll_rate, pitch_rate (16 bits each)
   input  logic [ReqDataWidth-1:0]        req_tdata,
   // kind
   input  logic [2:0]                     req_tuser,

   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // mode[2:0], mode_changed[3], send_telemetry[4], setpoint_kind[6:5],
   // motor_write[7], ratio_a[23:8], ratio_b[39:24], ratio_c[55:40],
   // ratio_d[71:56], bypass[72], bypass_write[73], zero fill[79:74]
   output logic [RspDataWidth-1:0]        rsp_tdata,

   input  logic                           csr_we,
   input  logic [CsrAddrWidth-1:0]        csr_addr,
   input  logic [LimitWidth-1:0]          csr_wdata
);

   logic [LimitWidth-1:0] xy_limit_ff;
   logic [LimitWidth-1:0] tilt_limit_ff;
   logic [LimitWidth-1:0] rate_limit_ff;
   logic [LimitWidth-1:0] takeoff_height_ff;
   logic [LimitWidth-1:0] landed_height_ff;

   logic                    in_valid_ff;
   logic [2:0]              in_kind_ff;
   logic [ReqDataWidth-1:0] in_data_ff;

   logic                    rsp_valid_ff;
   logic [RspDataWidth-1:0] rsp_data_ff;
   logic [RspDataWidth-1:0] rsp_data_in;

   mode_type mode_ff;
   mode_type mode_in;
   logic     bypass_ff;
   logic     bypass_in;

   logic rsp_load;
   logic advance;

   logic signed [FieldWidth-1:0] motor_a, motor_b, motor_c, motor_d;
   logic signed [FieldWidth-1:0] pos_x, pos_y, height;
   logic signed [FieldWidth-1:0] roll_angle, pitch_angle, roll_rate, pitch_rate;

   logic         unsafe;
   setpoint_type setpoint;
   logic         motors;
   logic         bypass_write;
   logic [FieldWidth-1:0] ratio_a, ratio_b, ratio_c, ratio_d;

   // handshake
   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && rsp_load;
   assign req_tready = !in_valid_ff || rsp_load;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         xy_limit_ff       <= XyLimitReset;
         tilt_limit_ff     <= TiltLimitReset;
         rate_limit_ff     <= RateLimitReset;
         takeoff_height_ff <= TakeoffHeightReset;
         landed_height_ff  <= LandedHeightReset;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_XY_LIMIT:       xy_limit_ff       <= csr_wdata;
            REG_TILT_LIMIT:     tilt_limit_ff     <= csr_wdata;
            REG_RATE_LIMIT:     rate_limit_ff     <= csr_wdata;
            REG_TAKEOFF_HEIGHT: takeoff_height_ff <= csr_wdata;
            REG_LANDED_HEIGHT:  landed_height_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff <= req_tuser;
         in_data_ff <= req_tdata;
      end
   end

   assign motor_a     = in_data_ff[15:0];
   assign motor_b     = in_data_ff[31:16];
   assign motor_c     = in_data_ff[47:32];
   assign motor_d     = in_data_ff[63:48];
   assign pos_x       = in_data_ff[79:64];
   assign pos_y       = in_data_ff[95:80];
   assign height      = in_data_ff[111:96];
   assign roll_angle  = in_data_ff[127:112];
   assign pitch_angle = in_data_ff[143:128];
   assign roll_rate   = in_data_ff[159:144];
   assign pitch_rate  = in_data_ff[175:160];

   assign unsafe = beyond(pos_x, xy_limit_ff) || beyond(pos_y, xy_limit_ff) ||
                   beyond(roll_angle, tilt_limit_ff) || beyond(pitch_angle, tilt_limit_ff) ||
                   beyond(roll_rate, rate_limit_ff) || beyond(pitch_rate, rate_limit_ff);

   assign ratio_a = motor_ratio(motor_a);
   assign ratio_b = motor_ratio(motor_b);
   assign ratio_c = motor_ratio(motor_c);
   assign ratio_d = motor_ratio(motor_d);

   // mode state register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_INIT;
         bypass_ff <= 1'b0;
      end else if (advance) begin
         mode_ff   <= mode_in;
         bypass_ff <= bypass_in;
      end
   end

   // next mode and tick outputs
   always_comb begin
      logic telemetry;
      mode_in      = mode_ff;
      setpoint     = SP_NONE;
      motors       = 1'b0;
      bypass_write = 1'b0;
      bypass_in    = bypass_ff;
      telemetry    = 1'b1;

      unique case (mode_ff)
         MODE_INIT: begin
            telemetry = 1'b0;
            if (in_kind_ff == CMD_START) begin
               mode_in = MODE_GROUND;
            end
         end
         MODE_GROUND: begin
            if (in_kind_ff == CMD_HOVER) begin
               mode_in = MODE_TAKEOFF;
            end else if (in_kind_ff == CMD_PWM) begin
               mode_in      = MODE_EXEC;
               motors       = 1'b1;
               bypass_in    = 1'b1;
               bypass_write = 1'b1;
            end
         end
         MODE_TAKEOFF: begin
            setpoint = SP_HOVER;
            if (above(height, takeoff_height_ff)) begin
               mode_in = MODE_HOVER;
            end
         end
         MODE_HOVER: begin
            setpoint = SP_HOVER;
            if (in_kind_ff == CMD_LAND) begin
               mode_in = MODE_LAND;
            end else if (in_kind_ff == CMD_PWM) begin
               mode_in      = MODE_EXEC;
               motors       = 1'b1;
               bypass_in    = 1'b1;
               bypass_write = 1'b1;
            end
         end
         MODE_LAND: begin
            setpoint = SP_LAND;
            if (below(height, landed_height_ff)) begin
               mode_in = MODE_GROUND;
            end
         end
         MODE_EXEC: begin
            if (unsafe) begin
               mode_in      = MODE_LAND;
               bypass_in    = 1'b0;
               bypass_write = 1'b1;
            end else if (in_kind_ff == CMD_HOVER) begin
               mode_in      = MODE_HOVER;
               bypass_in    = 1'b0;
               bypass_write = 1'b1;
            end else if (in_kind_ff == CMD_LAND) begin
               mode_in      = MODE_LAND;
               bypass_in    = 1'b0;
               bypass_write = 1'b1;
            end else if (in_kind_ff == CMD_PWM) begin
               motors = 1'b1;
            end
         end
         default: begin
            telemetry = 1'b0;
         end
      endcase

      if (motors) begin
         setpoint = SP_RESET;
      end

      rsp_data_in = {6'd0,
                     bypass_write,
                     bypass_in,
                     motors ? ratio_d : '0,
                     motors ? ratio_c : '0,
                     motors ? ratio_b : '0,
                     motors ? ratio_a : '0,
                     motors,
                     setpoint,
                     telemetry,
                     mode_in != mode_ff,
                     mode_in};
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
